// ----- sv/sme_pkg.sv -----
// Shared types and constants for the stack machine executor.
// No dependencies; every other file imports this package.
package sme_pkg;

   localparam int DATA_W      = 32;
   localparam int NUM_REGS    = 8;
   localparam int STACK_DEPTH = 256;
   localparam int STACK_AW    = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [DATA_W-1:0]   data_type;
   typedef logic [STACK_AW-1:0] stack_addr_type;
   typedef logic [2:0]          reg_idx_type;

   localparam reg_idx_type REG_A  = 3'd0;
   localparam reg_idx_type REG_IP = 3'd6;
   localparam reg_idx_type REG_SP = 3'd7;

   localparam data_type DEPTH_LIMIT = DATA_W'(STACK_DEPTH);

   typedef enum logic [2:0] {
      MODE_PUSH  = 3'd0,
      MODE_ADD   = 3'd1,
      MODE_POP   = 3'd2,
      MODE_SET   = 3'd3,
      MODE_MOVE  = 3'd4,
      MODE_PRINT = 3'd5,
      MODE_HALT  = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      REPORT_NONE  = 2'd0,
      REPORT_POP   = 2'd1,
      REPORT_PRINT = 2'd2
   } report_kind_type;

   // memory work left for the second stage
   typedef enum logic [1:0] {
      MEMOP_NONE = 2'd0,
      MEMOP_PUSH = 2'd1,
      MEMOP_ADD  = 2'd2,
      MEMOP_POP  = 2'd3
   } memop_type;

   typedef enum logic {
      PHASE_CLEAR = 1'b0,
      PHASE_RUN   = 1'b1
   } phase_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] immediate;
      logic [2:0]         first_reg;
      logic [2:0]         second_reg;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         report_kind;
      logic signed [31:0] report_value;
      logic signed [31:0] next_fetch;
      logic               stack_fault;
      logic               halted;
   } rsp_word_type;

   typedef struct packed {
      stack_addr_type rd_addr0;
      stack_addr_type rd_addr1;
      logic           wr_en;
      stack_addr_type wr_addr;
      data_type       wr_data;
   } mem_req_type;

endpackage

// ----- sv/stack_machine_executor_unit.sv -----
// Stack machine executor: one pre-decoded instruction per accepted word.
// Result registered in stage 2, then in the output queue. Throughput: one word per
// cycle while the queue has room; stage 2 forwards its stack write to a read issued
// in the same cycle. Reset: registers cleared (SP all ones), halt flag cleared, then
// a clearing pass zeroes all STACK_DEPTH (256) entries, one per cycle, req_ready low.
module stack_machine_executor_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sme_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sme_pkg::rsp_word_type rsp_word
);
   import sme_pkg::*;

   // clearing pass control
   phase_type       phase_ff, phase_in;
   stack_addr_type  clear_addr_ff, clear_addr_in;
   logic            clear_we;
   logic            run;

   // architectural state
   data_type        regs_ff [NUM_REGS];
   data_type        regs_in [NUM_REGS];
   logic            halt_ff, halt_in;

   // stage 2
   logic            s2_valid_ff;
   memop_type       s2_op_ff, s2_op_in;
   stack_addr_type  s2_waddr_ff, s2_waddr_in;
   data_type        s2_imm_ff;
   logic            s2_fwd0_ff, s2_fwd0_in;
   logic            s2_fwd1_ff, s2_fwd1_in;
   data_type        s2_fwd_data_ff;
   rsp_word_type    s2_rsp_ff, s2_rsp_in;

   logic            accept;
   data_type        sp, ip, sp_inc, sp_dec;
   logic            sp_ok, sp_inc_ok, sp_dec_ok;
   stack_addr_type  rd_addr0, rd_addr1;
   logic            fault;
   report_kind_type kind;
   data_type        value;

   data_type        mem_rd0, mem_rd1;
   data_type        rd0, rd1;
   logic            s2_wr_en;
   data_type        s2_wr_data;
   rsp_word_type    s2_rsp_out;
   mem_req_type     mem_req;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W-1:0] in_flight;

   // ---------------- clearing pass ----------------
   always_comb begin
      phase_in      = phase_ff;
      clear_addr_in = clear_addr_ff;
      unique case (phase_ff)
         PHASE_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == STACK_AW'(STACK_DEPTH - 1)) begin
               phase_in = PHASE_RUN;
            end
         end
         PHASE_RUN: phase_in = PHASE_RUN;
         default:   phase_in = PHASE_CLEAR;
      endcase
   end

   always_comb begin
      clear_we = 1'b0;
      run      = 1'b0;
      unique case (phase_ff)
         PHASE_CLEAR: clear_we = 1'b1;
         PHASE_RUN:   run      = 1'b1;
         default:     clear_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------- issue stage ----------------
   // room for this word is reserved in the queue before it is accepted
   assign in_flight = QCNT_W'(s2_valid_ff) + q_count;
   assign req_ready = run && (in_flight < QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   assign sp        = regs_ff[REG_SP];
   assign ip        = regs_ff[REG_IP];
   assign sp_inc    = sp + 1'b1;
   assign sp_dec    = sp - 1'b1;
   assign sp_ok     = sp < DEPTH_LIMIT;
   assign sp_inc_ok = sp_inc < DEPTH_LIMIT;
   assign sp_dec_ok = sp_dec < DEPTH_LIMIT;
   assign rd_addr0  = sp[STACK_AW-1:0];
   assign rd_addr1  = sp_dec[STACK_AW-1:0];

   always_comb begin
      regs_in     = regs_ff;
      halt_in     = halt_ff;
      s2_op_in    = MEMOP_NONE;
      s2_waddr_in = sp_dec[STACK_AW-1:0];
      fault       = 1'b0;
      kind        = REPORT_NONE;
      value       = '0;
      if (accept && !halt_ff) begin
         unique case (mode_type'(req_word.mode))
            MODE_PUSH: begin
               if (sp_inc_ok) begin
                  s2_op_in         = MEMOP_PUSH;
                  s2_waddr_in      = sp_inc[STACK_AW-1:0];
                  regs_in[REG_SP]  = sp_inc;
               end else begin
                  fault = 1'b1;
               end
               regs_in[REG_IP] = ip + 32'd2;
            end
            MODE_ADD: begin
               if (sp_ok && sp_dec_ok) begin
                  s2_op_in        = MEMOP_ADD;
                  regs_in[REG_SP] = sp_dec;
               end else begin
                  fault = 1'b1;
               end
               regs_in[REG_IP] = ip + 32'd1;
            end
            MODE_POP: begin
               if (sp_ok) begin
                  s2_op_in        = MEMOP_POP;
                  kind            = REPORT_POP;
                  regs_in[REG_SP] = sp_dec;
               end else begin
                  fault = 1'b1;
               end
               regs_in[REG_IP] = ip + 32'd1;
            end
            MODE_SET: begin
               // IP steps by 2, target written, IP steps by 1
               regs_in[REG_IP]             = ip + 32'd2;
               regs_in[req_word.first_reg] = $unsigned(req_word.immediate);
               regs_in[REG_IP]             = regs_in[REG_IP] + 32'd1;
            end
            MODE_MOVE: begin
               regs_in[REG_IP]              = ip + 32'd2;
               regs_in[req_word.second_reg] = regs_in[req_word.first_reg];
               regs_in[REG_IP]              = regs_in[REG_IP] + 32'd1;
            end
            MODE_PRINT: begin
               kind            = REPORT_PRINT;
               value           = regs_ff[REG_A];
               regs_in[REG_IP] = ip + 32'd1;
            end
            MODE_HALT: begin
               halt_in         = 1'b1;
               regs_in[REG_IP] = ip + 32'd1;
            end
            default: begin
               regs_in[REG_IP] = ip + 32'd1;
            end
         endcase
      end
      s2_rsp_in.report_kind  = kind;
      s2_rsp_in.report_value = $signed(value);
      s2_rsp_in.next_fetch   = $signed(regs_in[REG_IP]);
      s2_rsp_in.stack_fault  = fault;
      s2_rsp_in.halted       = halt_in;
   end

   // stage 2 writes at the same edge this read is issued: memory returns old data
   assign s2_fwd0_in = s2_wr_en && (s2_waddr_ff == rd_addr0);
   assign s2_fwd1_in = s2_wr_en && (s2_waddr_ff == rd_addr1);

   always_ff @(posedge clock) begin
      if (reset) begin
         foreach (regs_ff[i]) begin
            if (i == int'(REG_SP)) begin
               regs_ff[i] <= '1;
            end else begin
               regs_ff[i] <= '0;
            end
         end
         halt_ff         <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         regs_ff     <= regs_in;
         halt_ff     <= halt_in;
         s2_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff       <= s2_op_in;
      s2_waddr_ff    <= s2_waddr_in;
      s2_imm_ff      <= $unsigned(req_word.immediate);
      s2_fwd0_ff     <= s2_fwd0_in;
      s2_fwd1_ff     <= s2_fwd1_in;
      s2_fwd_data_ff <= s2_wr_data;
      s2_rsp_ff      <= s2_rsp_in;
   end

   // ---------------- stage 2: memory data, write back ----------------
   assign rd0 = s2_fwd0_ff ? s2_fwd_data_ff : mem_rd0;
   assign rd1 = s2_fwd1_ff ? s2_fwd_data_ff : mem_rd1;

   assign s2_wr_en   = s2_valid_ff && ((s2_op_ff == MEMOP_PUSH) || (s2_op_ff == MEMOP_ADD));
   assign s2_wr_data = (s2_op_ff == MEMOP_PUSH) ? s2_imm_ff : rd0 + rd1;

   always_comb begin
      s2_rsp_out = s2_rsp_ff;
      if (s2_op_ff == MEMOP_POP) begin
         s2_rsp_out.report_value = $signed(rd0);
      end
   end

   always_comb begin
      mem_req.rd_addr0 = rd_addr0;
      mem_req.rd_addr1 = rd_addr1;
      if (clear_we) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = clear_addr_ff;
         mem_req.wr_data = '0;
      end else begin
         mem_req.wr_en   = s2_wr_en;
         mem_req.wr_addr = s2_waddr_ff;
         mem_req.wr_data = s2_wr_data;
      end
   end

   sme_stack_mem u_stack_mem (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_data0 (mem_rd0),
      .rd_data1 (mem_rd1)
   );

   sme_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s2_valid_ff),
      .push_word  (s2_rsp_out),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .count      (q_count)
   );

endmodule

// ----- sv/sme_stack_mem.sv -----
// Stack memory: one write port, two read ports, registered read data.
// Depends on sme_pkg.
module sme_stack_mem (
   input  logic                clock,
   input  sme_pkg::mem_req_type mem_req,
   output sme_pkg::data_type   rd_data0,
   output sme_pkg::data_type   rd_data1
);
   import sme_pkg::*;

   data_type mem [STACK_DEPTH];
   data_type rd0_ff;
   data_type rd1_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd0_ff <= mem[mem_req.rd_addr0];
      rd1_ff <= mem[mem_req.rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ----- sv/sme_rsp_queue.sv -----
// Small output queue that decouples the execute pipe from the result channel.
// Depends on sme_pkg.
module sme_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  sme_pkg::rsp_word_type     push_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sme_pkg::rsp_word_type     rsp_word,
   output logic [sme_pkg::QCNT_W-1:0] count
);
   import sme_pkg::*;

   rsp_word_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign pop = (count_ff != '0) && rsp_ready;

   always_comb begin
      head_in  = pop ? ptr_next(head_ff) : head_ff;
      tail_in  = push_valid ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[tail_ff] <= push_word;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entries_ff[head_ff];
   assign count     = count_ff;

endmodule

// ----- sv/sme_checker.sv -----
// Port-level checks for stack_machine_executor_unit, attached by bind.
// Depends on sme_pkg.
module sme_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input sme_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input sme_pkg::rsp_word_type rsp_word
);
   import sme_pkg::*;

   // nothing leaves and nothing is taken right after reset (clearing pass)
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("activity right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before accept");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("rsp_word changed while stalled");

   // a halted machine reports nothing and never faults
   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.halted |->
         (rsp_word.report_kind == REPORT_NONE) && (rsp_word.report_value == 0)
         && !rsp_word.stack_fault)
      else $error("halted word carries a report or fault");

   a_fault_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.stack_fault |->
         (rsp_word.report_kind == REPORT_NONE) && (rsp_word.report_value == 0))
      else $error("faulted word carries a report");

endmodule

bind stack_machine_executor_unit sme_checker u_sme_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench for stack_machine_executor_unit: random and directed
// instruction words checked against an in-bench model of the machine state.
// Depends on sme_pkg (sv/sme_pkg.sv) and the executor RTL.
module tb_top;
   import sme_pkg::*;

   localparam logic [2:0]  MODE_UNUSED  = 3'd7;
   localparam reg_idx_type REG_B        = 3'd1;
   localparam reg_idx_type REG_C        = 3'd2;
   localparam reg_idx_type REG_F        = 3'd5;
   localparam int          RANDOM_ITEMS = 900;
   localparam int          TAIL_ITEMS   = 100;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   stack_machine_executor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // machine state as the executor should hold it
   data_type     vm_regs [NUM_REGS];
   data_type     vm_stack [STACK_DEPTH];
   logic         vm_halted;

   req_word_type pending_q [$];
   rsp_word_type expected_q [$];

   int error_count = 0;
   int accepted    = 0;
   int checked     = 0;
   int fault_count = 0;
   int pop_count   = 0;
   int print_count = 0;
   int mode_count [8];
   int send_pct    = 0;
   int take_pct    = 0;
   int send_gap    = 0;
   int take_gap    = 0;

   function automatic logic in_stack(data_type idx);
      return idx < DEPTH_LIMIT;
   endfunction

   function automatic rsp_word_type execute_instr(req_word_type w);
      rsp_word_type r;
      data_type     sp;
      r  = '0;
      sp = vm_regs[REG_SP];
      if (vm_halted) begin
         r.next_fetch = vm_regs[REG_IP];
         r.halted     = 1'b1;
         return r;
      end
      case (w.mode)
         MODE_PUSH: begin
            if (in_stack(sp + 1)) begin
               vm_stack[STACK_AW'(sp + 1)] = w.immediate;
               vm_regs[REG_SP] = sp + 1;
            end else begin
               r.stack_fault = 1'b1;
            end
            vm_regs[REG_IP] += 2;
         end
         MODE_ADD: begin
            if (in_stack(sp) && in_stack(sp - 1)) begin
               vm_stack[STACK_AW'(sp - 1)] = vm_stack[STACK_AW'(sp - 1)]
                                           + vm_stack[STACK_AW'(sp)];
               vm_regs[REG_SP] = sp - 1;
            end else begin
               r.stack_fault = 1'b1;
            end
            vm_regs[REG_IP] += 1;
         end
         MODE_POP: begin
            if (in_stack(sp)) begin
               r.report_kind  = REPORT_POP;
               r.report_value = vm_stack[STACK_AW'(sp)];
               vm_regs[REG_SP] = sp - 1;
            end else begin
               r.stack_fault = 1'b1;
            end
            vm_regs[REG_IP] += 1;
         end
         // IP is bumped by 2 before the register write and by 1 after it, even when IP is written
         MODE_SET: begin
            vm_regs[REG_IP] += 2;
            vm_regs[w.first_reg] = w.immediate;
            vm_regs[REG_IP] += 1;
         end
         MODE_MOVE: begin
            vm_regs[REG_IP] += 2;
            vm_regs[w.second_reg] = vm_regs[w.first_reg];
            vm_regs[REG_IP] += 1;
         end
         MODE_PRINT: begin
            r.report_kind  = REPORT_PRINT;
            r.report_value = vm_regs[REG_A];
            vm_regs[REG_IP] += 1;
         end
         MODE_HALT: begin
            vm_halted = 1'b1;
            vm_regs[REG_IP] += 1;
         end
         default: vm_regs[REG_IP] += 1;
      endcase
      r.next_fetch = vm_regs[REG_IP];
      r.halted     = vm_halted;
      return r;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 40;
      endcase
   endfunction

   function automatic data_type rand_word();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return 32'h7fff_ffff;
         2:       return 32'h8000_0000;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_instr(input logic [2:0] mode, input data_type imm,
                              input reg_idx_type r1, input reg_idx_type r2);
      req_word_type w;
      w.mode       = mode;
      w.immediate  = imm;
      w.first_reg  = r1;
      w.second_reg = r2;
      pending_q.push_back(w);
   endtask

   task automatic queue_random_group();
      int          pick;
      int          burst;
      data_type    val;
      reg_idx_type r1;
      reg_idx_type r2;
      pick = $urandom_range(0, 99);
      r1   = reg_idx_type'($urandom_range(0, 7));
      r2   = reg_idx_type'($urandom_range(0, 7));
      if (pick < 28) begin
         queue_instr(MODE_PUSH, rand_word(), r1, r2);
      end else if (pick < 42) begin
         queue_instr(MODE_POP, rand_word(), r1, r2);
      end else if (pick < 54) begin
         queue_instr(MODE_ADD, rand_word(), r1, r2);
      end else if (pick < 63) begin
         queue_instr(MODE_PRINT, rand_word(), r1, r2);
      end else if (pick < 75) begin
         val = rand_word();
         // SP writes mostly land inside the stack so that pushes and pops work
         if (r1 == REG_SP) begin
            case ($urandom_range(0, 9))
               0:       val = '1;
               1:       val = DEPTH_LIMIT - 1;
               2:       val = rand_word();
               default: val = $urandom_range(0, STACK_DEPTH - 1);
            endcase
         end
         queue_instr(MODE_SET, val, r1, r2);
      end else if (pick < 87) begin
         if (r2 == REG_SP && $urandom_range(0, 3) != 0)
            r2 = reg_idx_type'($urandom_range(0, 5));
         queue_instr(MODE_MOVE, rand_word(), r1, r2);
      end else if (pick < 90) begin
         queue_instr(MODE_UNUSED, rand_word(), r1, r2);
      end else begin
         // fill then drain: a well-formed run of stack traffic
         burst = $urandom_range(2, 8);
         repeat (burst)
            queue_instr(MODE_PUSH, rand_word(), reg_idx_type'($urandom_range(0, 7)),
                        reg_idx_type'($urandom_range(0, 7)));
         repeat (burst)
            queue_instr($urandom_range(0, 1) ? MODE_ADD : MODE_POP, rand_word(),
                        reg_idx_type'($urandom_range(0, 7)),
                        reg_idx_type'($urandom_range(0, 7)));
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // driver: predicts each word at the edge it is taken
   always @(posedge clock) begin : driver
      rsp_word_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = execute_instr(req_word);
            expected_q.push_back(predicted);
            mode_count[req_word.mode]++;
            accepted++;
            if (accepted % 64 == 0)
               send_pct = pick_idle_pct();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_q.size() > TAIL_ITEMS &&
                         $urandom_range(0, 99) < send_pct) begin
               send_gap   = $urandom_range(1, 9) - 1;
               req_valid <= 1'b0;
            end else begin
               req_word  <= pending_q.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor: random back-pressure and in-order compare
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, rsp_word);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("report_kind", 32'(want.report_kind), 32'(rsp_word.report_kind));
               check_field("report_value", want.report_value, rsp_word.report_value);
               check_field("next_fetch", want.next_fetch, rsp_word.next_fetch);
               check_field("stack_fault", 32'(want.stack_fault), 32'(rsp_word.stack_fault));
               check_field("halted", 32'(want.halted), 32'(rsp_word.halted));
               checked++;
               if (want.stack_fault) fault_count++;
               if (want.report_kind == REPORT_POP) pop_count++;
               if (want.report_kind == REPORT_PRINT) print_count++;
               if (checked % 64 == 0)
                  take_pct = pick_idle_pct();
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < take_pct) begin
            take_gap   = $urandom_range(1, 9) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      foreach (vm_regs[i]) vm_regs[i] = '0;
      foreach (vm_stack[i]) vm_stack[i] = '0;
      foreach (mode_count[i]) mode_count[i] = 0;
      vm_regs[REG_SP] = '1;
      vm_halted       = 1'b0;

      // empty stack faults, wrapping add, single-entry add
      queue_instr(MODE_POP, '0, REG_A, REG_A);
      queue_instr(MODE_ADD, '0, REG_A, REG_A);
      queue_instr(MODE_PUSH, 32'h7fff_ffff, REG_A, REG_A);
      queue_instr(MODE_ADD, '0, REG_A, REG_A);
      queue_instr(MODE_PUSH, 32'h0000_0001, REG_A, REG_A);
      queue_instr(MODE_ADD, '1, REG_SP, REG_SP);
      queue_instr(MODE_POP, '0, REG_A, REG_A);
      queue_instr(MODE_PRINT, '0, REG_A, REG_A);
      queue_instr(MODE_SET, 32'h8000_0000, REG_A, REG_A);
      queue_instr(MODE_PRINT, '0, REG_A, REG_A);
      queue_instr(MODE_SET, '1, REG_F, REG_A);
      queue_instr(MODE_MOVE, '0, REG_F, REG_A);
      queue_instr(MODE_PRINT, '0, REG_A, REG_A);
      // top of stack: last push fits, the next one faults
      queue_instr(MODE_SET, DEPTH_LIMIT - 2, REG_SP, REG_A);
      queue_instr(MODE_PUSH, 32'hdead_beef, REG_A, REG_A);
      queue_instr(MODE_PUSH, 32'h1234_5678, REG_A, REG_A);
      queue_instr(MODE_POP, '0, REG_A, REG_A);
      // SP far out of range, compared unsigned
      queue_instr(MODE_SET, 32'h8000_0000, REG_SP, REG_A);
      queue_instr(MODE_PUSH, 32'h5555_5555, REG_A, REG_A);
      queue_instr(MODE_MOVE, '0, REG_SP, REG_B);
      // IP as move source, set target and move destination
      queue_instr(MODE_MOVE, '0, REG_IP, REG_C);
      queue_instr(MODE_SET, 32'h7fff_ffff, REG_IP, REG_A);
      queue_instr(MODE_MOVE, '0, REG_A, REG_IP);
      queue_instr(MODE_MOVE, '0, REG_IP, REG_IP);
      queue_instr(MODE_UNUSED, '1, REG_SP, REG_SP);
      queue_instr(MODE_SET, '1, REG_SP, REG_SP);

      while (pending_q.size() < RANDOM_ITEMS + 26)
         queue_random_group();
      // halt last; whatever follows must be ignored
      queue_instr(MODE_HALT, rand_word(), REG_A, REG_A);
      repeat (4)
         queue_instr(3'($urandom_range(0, 7)), rand_word(),
                     reg_idx_type'($urandom_range(0, 7)), reg_idx_type'($urandom_range(0, 7)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_q.size() != 0 || req_valid) @(negedge clock);
      while (expected_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $write("Ran %0d words: push %0d, add %0d, pop %0d, set %0d, ",
             accepted, mode_count[MODE_PUSH], mode_count[MODE_ADD], mode_count[MODE_POP],
             mode_count[MODE_SET]);
      $display("move %0d, print %0d, halt %0d, unused %0d",
               mode_count[MODE_MOVE], mode_count[MODE_PRINT],
               mode_count[MODE_HALT], mode_count[MODE_UNUSED]);
      $display("Checked %0d results: %0d stack faults, %0d pops and %0d prints reported",
               checked, fault_count, pop_count, print_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("%0t: timeout, %0d results still outstanding", $time, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- stack_machine_executor_unit.f -----
sv/sme_pkg.sv
sv/sme_stack_mem.sv
sv/sme_rsp_queue.sv
sv/stack_machine_executor_unit.sv
sv/sme_checker.sv
test/tb_top.sv
